@@ rtl/abcs_pkg.sv @@
// Shared types, codes and helpers for the AABB body collision step block.
// Depends on nothing; every other file of the block imports it.
package abcs_pkg;

  // Number of collider and body indexes tracked in the membership maps.
  localparam int MAX_OBJECTS = 64;
  localparam int MAP_IDX_W   = $clog2(MAX_OBJECTS);

  // Divider sizes: a 33-bit displacement shifted up by 16 over a 16-bit dt.
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Shared multiplier operand width (signed).
  localparam int MUL_W = 33;

  // Item kinds.
  localparam logic [2:0] KIND_BEGIN    = 3'd0;
  localparam logic [2:0] KIND_COLLIDER = 3'd1;
  localparam logic [2:0] KIND_BODY     = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_LOAD     = 3'd4;

  // Event codes.
  localparam logic [2:0] EV_TICK       = 3'd0;
  localparam logic [2:0] EV_TRIG_ENTER = 3'd1;
  localparam logic [2:0] EV_TRIG_EXIT  = 3'd2;
  localparam logic [2:0] EV_COLL_ENTER = 3'd3;
  localparam logic [2:0] EV_COLL_EXIT  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_X   = 2'd2;
  localparam logic [1:0] CFG_SIZE_Y   = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        dt;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic               is_trigger;
    logic [5:0]         object_id;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        skip_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [5:0]         event_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               grounded;
    logic               skipped;
  } out_item_t;

  // Divider request from the sequencer.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/aabb_body_collision_step.sv @@
// Top level of the AABB body collision step: sequencer, body state, maps.
// Depends on abcs_pkg, abcs_mul and abcs_div.
//
//  Channel | Signals                               | Direction
//  in      | in_valid, in_ready, in_data           | request into the block
//  out     | out_valid, out_ready, out_data        | event request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, data | register write into block
//
// Load, skipped begin and ignored items are handled in idle; begin moves the
// body through the shared multiplier; collider and body items run the
// overlap compares in S_OV1 to S_OV3; end runs two 49-bit divisions on the
// shared divider and four squares on the shared multiplier.
// Reset is synchronous; it clears the body state, maps and offsets and sets both sizes to 65536.
// A pending event waits in the output register; the next request is only
// taken once the sequencer is back in idle.
module aabb_body_collision_step
  import abcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_MOVX, S_MOVY, S_MOVE2, S_BOX,
    S_OV1, S_OV2, S_OV3,
    S_DIVX, S_DWX, S_DIVY, S_DWY,
    S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQ5, S_CMP,
    S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [31:0] off_x_r, off_y_r;
  logic [30:0]        size_x_r, size_y_r;

  // Body state.
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [31:0] prior_x_r, prior_y_r, box_left_r, box_top_r;
  logic [MAX_OBJECTS-1:0] trig_map_r, cont_map_r;
  logic               on_ground_r;
  logic [15:0]        skip_cnt_r;
  logic               tick_skipped_r;

  // Working registers.
  in_item_t           item_r;
  logic signed [33:0] lft_r, top_r, rgt_r, bot_r, iw_r, ih_r;
  logic               ov_r;
  logic signed [31:0] ax_r, ay_r;
  logic               neg_r;
  logic [63:0]        la_r, lv_r;
  logic [2:0]         ev_r;
  logic [5:0]         ev_id_r;
  logic               ev_skp_r;

  // Output register.
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Shared units.
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_r;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  abcs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));
  abcs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Handshake outputs.
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Combinational helpers.
  logic [MAP_IDX_W-1:0] idx;
  logic                 id_ok;
  logic signed [32:0]   dx, dy;
  logic [32:0]          dmag;
  logic signed [33:0]   bl, bt, br, bb, cl, ct, cr, cb;
  logic signed [49:0]   quo_s;
  logic signed [31:0]   mv;

  always_comb begin
    idx   = item_r.object_id[MAP_IDX_W-1:0];
    id_ok = (32'(item_r.object_id) < MAX_OBJECTS);
    dx    = 33'(pos_x_r) - 33'(prior_x_r);
    dy    = 33'(pos_y_r) - 33'(prior_y_r);
    bl    = 34'(box_left_r);
    bt    = 34'(box_top_r);
    br    = bl + {3'b000, size_x_r};
    bb    = bt + {3'b000, size_y_r};
    cl    = 34'(item_r.coord_x);
    ct    = 34'(item_r.coord_y);
    cr    = cl + {3'b000, item_r.extent_x};
    cb    = ct + {3'b000, item_r.extent_y};
    quo_s = neg_r ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    mv    = prod_r[47:16];
  end

  // Multiplier operand selection by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MOVX: begin mul_a = MUL_W'(vel_x_r); mul_b = MUL_W'({1'b0, item_r.dt}); end
      S_MOVY: begin mul_a = MUL_W'(vel_y_r); mul_b = MUL_W'({1'b0, item_r.dt}); end
      S_SQ1:  begin mul_a = MUL_W'(ax_r);    mul_b = MUL_W'(ax_r); end
      S_SQ2:  begin mul_a = MUL_W'(ay_r);    mul_b = MUL_W'(ay_r); end
      S_SQ3:  begin mul_a = MUL_W'(vel_x_r); mul_b = MUL_W'(vel_x_r); end
      S_SQ4:  begin mul_a = MUL_W'(vel_y_r); mul_b = MUL_W'(vel_y_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider request: magnitude of the displacement shifted up by 16.
  always_comb begin
    div_req.start = (state_r == S_DIVX) || (state_r == S_DIVY);
    div_req.den   = item_r.dt;
    if (state_r == S_DIVY) begin
      dmag = dy[32] ? -dy : dy;
    end else begin
      dmag = dx[32] ? -dx : dx;
    end
    div_req.num = {dmag, 16'h0000};
  end

  // Sequencer, body state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      off_x_r        <= '0;
      off_y_r        <= '0;
      size_x_r       <= 31'd65536;
      size_y_r       <= 31'd65536;
      pos_x_r        <= '0;
      pos_y_r        <= '0;
      vel_x_r        <= '0;
      vel_y_r        <= '0;
      prior_x_r      <= '0;
      prior_y_r      <= '0;
      box_left_r     <= '0;
      box_top_r      <= '0;
      trig_map_r     <= '0;
      cont_map_r     <= '0;
      on_ground_r    <= 1'b0;
      skip_cnt_r     <= '0;
      tick_skipped_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // Drop the event once it has been taken, unless a new one replaces it.
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OFFSET_X: off_x_r  <= cfg_data;
          CFG_OFFSET_Y: off_y_r  <= cfg_data;
          CFG_SIZE_X:   size_x_r <= cfg_data[30:0];
          CFG_SIZE_Y:   size_y_r <= cfg_data[30:0];
          default:      ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            case (in_data.kind)
              KIND_LOAD: begin
                pos_x_r        <= in_data.coord_x;
                pos_y_r        <= in_data.coord_y;
                vel_x_r        <= in_data.vel_x;
                vel_y_r        <= in_data.vel_y;
                skip_cnt_r     <= in_data.skip_ticks;
                on_ground_r    <= 1'b0;
                tick_skipped_r <= 1'b0;
              end
              KIND_BEGIN: begin
                if (skip_cnt_r != 16'd0) begin
                  skip_cnt_r     <= skip_cnt_r - 16'd1;
                  tick_skipped_r <= 1'b1;
                end else begin
                  tick_skipped_r <= 1'b0;
                  prior_x_r      <= pos_x_r;
                  prior_y_r      <= pos_y_r;
                  state_r        <= S_MOVX;
                end
              end
              KIND_COLLIDER, KIND_BODY: begin
                if (!tick_skipped_r) begin
                  state_r <= S_OV1;
                end
              end
              KIND_END: begin
                tick_skipped_r <= 1'b0;
                ev_r           <= EV_TICK;
                ev_id_r        <= '0;
                ev_skp_r       <= tick_skipped_r;
                if (tick_skipped_r || in_data.dt == 16'd0) begin
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_DIVX;
                end
              end
              default: ;
            endcase
          end
        end

        // Motion: position plus floor of velocity times dt.
        S_MOVX: state_r <= S_MOVY;
        S_MOVY: begin
          pos_x_r <= sat32(50'(pos_x_r) + 50'(mv));
          state_r <= S_MOVE2;
        end
        S_MOVE2: begin
          pos_y_r <= sat32(50'(pos_y_r) + 50'(mv));
          state_r <= S_BOX;
        end
        // Bottom-centred collider box.
        S_BOX: begin
          box_left_r <= sat32(50'(pos_x_r) + 50'(off_x_r) - 50'({1'b0, size_x_r[30:1]}));
          box_top_r  <= sat32(50'(pos_y_r) + 50'(off_y_r) - 50'({1'b0, size_y_r}));
          state_r    <= S_IDLE;
        end

        // Overlap: intersection edges, then extents, then the action.
        S_OV1: begin
          if (!id_ok) begin
            state_r <= S_IDLE;
          end else begin
            lft_r   <= (bl > cl) ? bl : cl;
            top_r   <= (bt > ct) ? bt : ct;
            rgt_r   <= (br < cr) ? br : cr;
            bot_r   <= (bb < cb) ? bb : cb;
            state_r <= S_OV2;
          end
        end
        S_OV2: begin
          ov_r    <= (lft_r < rgt_r) && (top_r < bot_r);
          iw_r    <= rgt_r - lft_r;
          ih_r    <= bot_r - top_r;
          state_r <= S_OV3;
        end
        S_OV3: begin
          ev_id_r  <= item_r.object_id;
          ev_skp_r <= 1'b0;
          if (item_r.kind == KIND_BODY) begin
            if (ov_r && !cont_map_r[idx]) begin
              cont_map_r[idx] <= 1'b1;
              ev_r            <= EV_COLL_ENTER;
              state_r         <= S_EMIT;
            end else if (!ov_r && cont_map_r[idx]) begin
              cont_map_r[idx] <= 1'b0;
              ev_r            <= EV_COLL_EXIT;
              state_r         <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (item_r.is_trigger) begin
            if (ov_r && !trig_map_r[idx]) begin
              trig_map_r[idx] <= 1'b1;
              ev_r            <= EV_TRIG_ENTER;
              state_r         <= S_EMIT;
            end else if (!ov_r && trig_map_r[idx]) begin
              trig_map_r[idx] <= 1'b0;
              ev_r            <= EV_TRIG_EXIT;
              state_r         <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
            if (ov_r) begin
              // Push out along the axis of least overlap.
              if (iw_r < ih_r) begin
                if (bl < lft_r) begin
                  pos_x_r <= sat32(50'(pos_x_r) - 50'(iw_r));
                end else begin
                  pos_x_r <= sat32(50'(pos_x_r) + 50'(iw_r));
                end
              end else if (bt < top_r) begin
                pos_y_r     <= sat32(50'(pos_y_r) - 50'(ih_r));
                on_ground_r <= 1'b1;
              end else begin
                pos_y_r <= sat32(50'(pos_y_r) + 50'(ih_r));
              end
            end
          end
        end

        // End of tick: displacement over dt, truncated toward zero.
        S_DIVX: begin
          neg_r   <= dx[32];
          state_r <= S_DWX;
        end
        S_DWX: begin
          if (div_rsp.done) begin
            ax_r    <= sat32(quo_s);
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          neg_r   <= dy[32];
          state_r <= S_DWY;
        end
        S_DWY: begin
          if (div_rsp.done) begin
            ay_r    <= sat32(quo_s);
            state_r <= S_SQ1;
          end
        end
        // Squared lengths through the shared multiplier.
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: begin
          la_r    <= prod_r[63:0];
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          la_r    <= la_r + prod_r[63:0];
          state_r <= S_SQ4;
        end
        S_SQ4: begin
          lv_r    <= prod_r[63:0];
          state_r <= S_SQ5;
        end
        S_SQ5: begin
          lv_r    <= lv_r + prod_r[63:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (la_r < lv_r) begin
            vel_x_r <= ax_r;
            vel_y_r <= ay_r;
          end
          state_r <= S_EMIT;
        end

        // Hand the event to the output register once it is free.
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.event_res <= ev_r;
            out_data_r.event_id  <= ev_id_r;
            out_data_r.pos_x     <= pos_x_r;
            out_data_r.pos_y     <= pos_y_r;
            out_data_r.speed_x   <= vel_x_r;
            out_data_r.speed_y   <= vel_y_r;
            out_data_r.grounded  <= on_ground_r;
            out_data_r.skipped   <= ev_skp_r;
            state_r              <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The divider is never left running while a new request can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // A load request always leaves the body off the ground.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_LOAD) |=> !on_ground_r)
    else $error("grounded after load");

  // Only a tick-done event may report a skipped tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.skipped || out_data.event_res == EV_TICK))
    else $error("skipped flag on a membership event");

endmodule

@@ rtl/abcs_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on abcs_pkg for the operand width.
module abcs_mul
  import abcs_pkg::*;
(
  input  logic                        clk,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   prod_r
);

  // One multiply per cycle; the product is registered and ready in the next cycle.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

@@ rtl/abcs_div.sv @@
// Restoring unsigned divider that retires one quotient bit per cycle.
// Depends on abcs_pkg for the widths and the request and status structs.
module abcs_div
  import abcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
  end

  // Iteration control and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      quo_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (!diff[DIV_DEN_W]) begin
        rem_r <= diff[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ tb/aabb_body_collision_step_checker.sv @@
// Watches the request, event and register channels of the AABB body collision step,
// predicts every event from its own copy of the body state and compares.
// Depends on abcs_pkg for the payload types and the kind, event and register codes.
`timescale 1ns / 1ps

module aabb_body_collision_step_checker
  import abcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          events_checked
);

  // Register copy.
  longint off_x, off_y, box_w, box_h;

  // Body copy.
  longint body_x, body_y, body_vx, body_vy, start_x, start_y, box_l, box_t;
  bit [MAX_OBJECTS-1:0] trig_inside, body_touch;
  bit     grounded_now, tick_skip;
  int     skip_left;

  out_item_t expected_events[$];

  assign pending = expected_events.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Intersection of the body box with another box; true only for positive area.
  function automatic bit boxes_overlap(longint l, longint t, longint w, longint h,
                                       output longint il, output longint it,
                                       output longint iw, output longint ih);
    longint lo_x, lo_y, hi_x, hi_y;
    lo_x = (box_l > l) ? box_l : l;
    lo_y = (box_t > t) ? box_t : t;
    hi_x = (box_l + box_w < l + w) ? box_l + box_w : l + w;
    hi_y = (box_t + box_h < t + h) ? box_t + box_h : t + h;
    il = lo_x;
    it = lo_y;
    iw = hi_x - lo_x;
    ih = hi_y - lo_y;
    return (lo_x < hi_x) && (lo_y < hi_y);
  endfunction

  function automatic void queue_event(logic [2:0] ev, logic [5:0] id, bit skp);
    out_item_t e;
    e.event_res = ev;
    e.event_id  = id;
    e.pos_x     = body_x[31:0];
    e.pos_y     = body_y[31:0];
    e.speed_x   = body_vx[31:0];
    e.speed_y   = body_vy[31:0];
    e.grounded  = grounded_now;
    e.skipped   = skp;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void reset_body();
    off_x = 0; off_y = 0; box_w = 65536; box_h = 65536;
    body_x = 0; body_y = 0; body_vx = 0; body_vy = 0;
    start_x = 0; start_y = 0; box_l = 0; box_t = 0;
    trig_inside = '0; body_touch = '0;
    grounded_now = 0; tick_skip = 0; skip_left = 0;
  endfunction

  // Advances the body by one request and queues the event it causes, if any.
  function automatic void advance_body(in_item_t r);
    longint cx, cy, ex, ey, il, it, iw, ih, dtl, ax, ay;
    longint unsigned len_a, len_v;
    bit hit, skp;
    cx  = r.coord_x;
    cy  = r.coord_y;
    ex  = longint'(r.extent_x);
    ey  = longint'(r.extent_y);
    dtl = longint'(r.dt);
    case (r.kind)
      KIND_LOAD: begin
        body_x = cx; body_y = cy;
        body_vx = r.vel_x; body_vy = r.vel_y;
        skip_left = r.skip_ticks;
        grounded_now = 0; tick_skip = 0;
      end
      KIND_BEGIN: begin
        if (skip_left > 0) begin
          skip_left--;
          tick_skip = 1;
        end else begin
          tick_skip = 0;
          start_x = body_x; start_y = body_y;
          body_x = clamp32(body_x + ((body_vx * dtl) >>> 16));
          body_y = clamp32(body_y + ((body_vy * dtl) >>> 16));
          box_l = clamp32(body_x + off_x - (box_w >> 1));
          box_t = clamp32(body_y + off_y - box_h);
        end
      end
      KIND_COLLIDER: begin
        if (!tick_skip) begin
          hit = boxes_overlap(cx, cy, ex, ey, il, it, iw, ih);
          if (r.is_trigger) begin
            if (hit && !trig_inside[r.object_id]) begin
              trig_inside[r.object_id] = 1;
              queue_event(EV_TRIG_ENTER, r.object_id, 0);
            end else if (!hit && trig_inside[r.object_id]) begin
              trig_inside[r.object_id] = 0;
              queue_event(EV_TRIG_EXIT, r.object_id, 0);
            end
          end else if (hit) begin
            // Push out along the axis of least overlap.
            if (iw < ih) begin
              if (box_l < il) body_x = clamp32(body_x - iw);
              else body_x = clamp32(body_x + iw);
            end else if (box_t < it) begin
              body_y = clamp32(body_y - ih);
              grounded_now = 1;
            end else begin
              body_y = clamp32(body_y + ih);
            end
          end
        end
      end
      KIND_BODY: begin
        if (!tick_skip) begin
          hit = boxes_overlap(cx, cy, ex, ey, il, it, iw, ih);
          if (hit && !body_touch[r.object_id]) begin
            body_touch[r.object_id] = 1;
            queue_event(EV_COLL_ENTER, r.object_id, 0);
          end else if (!hit && body_touch[r.object_id]) begin
            body_touch[r.object_id] = 0;
            queue_event(EV_COLL_EXIT, r.object_id, 0);
          end
        end
      end
      KIND_END: begin
        skp = tick_skip;
        tick_skip = 0;
        if (!skp && dtl != 0) begin
          // Keep the shorter of the commanded and the actual velocity.
          ax = clamp32(((body_x - start_x) * 65536) / dtl);
          ay = clamp32(((body_y - start_y) * 65536) / dtl);
          len_a = longint'(ax * ax) + longint'(ay * ay);
          len_v = longint'(body_vx * body_vx) + longint'(body_vy * body_vy);
          if (len_a < len_v) begin
            body_vx = ax;
            body_vy = ay;
          end
        end
        queue_event(EV_TICK, '0, skp);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (fail_count < 40) begin
      $display("%0t: event field %s is %0h, expected %0h", $realtime, field, got, want);
    end
    fail_count++;
  endtask

  // Channel monitor: compare first, then predict from the new request.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      reset_body();
      expected_events.delete();
      fail_count = 0;
      events_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("event_res (unexpected event)", 32'(out_data.event_res), '0);
        end else begin
          e = expected_events.pop_front();
          events_checked++;
          if (out_data.event_res !== e.event_res)
            report_mismatch("event_res", 32'(out_data.event_res), 32'(e.event_res));
          if (out_data.event_id !== e.event_id)
            report_mismatch("event_id", 32'(out_data.event_id), 32'(e.event_id));
          if (out_data.pos_x !== e.pos_x) report_mismatch("pos_x", out_data.pos_x, e.pos_x);
          if (out_data.pos_y !== e.pos_y) report_mismatch("pos_y", out_data.pos_y, e.pos_y);
          if (out_data.speed_x !== e.speed_x)
            report_mismatch("speed_x", out_data.speed_x, e.speed_x);
          if (out_data.speed_y !== e.speed_y)
            report_mismatch("speed_y", out_data.speed_y, e.speed_y);
          if (out_data.grounded !== e.grounded)
            report_mismatch("grounded", 32'(out_data.grounded), 32'(e.grounded));
          if (out_data.skipped !== e.skipped)
            report_mismatch("skipped", 32'(out_data.skipped), 32'(e.skipped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OFFSET_X: off_x = longint'(signed'(cfg_data));
          CFG_OFFSET_Y: off_y = longint'(signed'(cfg_data));
          CFG_SIZE_X:   box_w = longint'(cfg_data[30:0]);
          CFG_SIZE_Y:   box_h = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_body(in_data);
    end
  end

endmodule

@@ tb/aabb_body_collision_step_test.sv @@
// Top of the AABB body collision step testbench: clock, reset, request and
// register stimulus, event back-pressure and verdict. Depends on abcs_pkg,
// the block and aabb_body_collision_step_checker.
`timescale 1ns / 1ps

module aabb_body_collision_step_test;
  import abcs_pkg::*;

  localparam int UNIT       = 65536;
  localparam int ITEM_GOAL  = 1750;
  localparam int SETTLE     = 200;
  localparam int CYCLE_CAP  = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_OFFSET_X;
  logic [31:0] cfg_data = '0;

  int  fail_count, pending, events_checked;
  int  requests_sent = 0;
  int  settings_used = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  jitter_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aabb_body_collision_step dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  aabb_body_collision_step_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending, .events_checked
  );

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Run exceeded %0d cycles with %0d events outstanding", CYCLE_CAP, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Event back-pressure: a fresh stall length after every accepted event.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) stall_left = jitter_on ? $urandom_range(0, 18) : 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One request; valid stays high into the next request when there is no gap.
  task automatic send_request(in_item_t r);
    int gap;
    gap = jitter_on ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Wait for every expected event, then for the longest request to finish.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                            logic [31:0] sy);
    logic [31:0] vals [4];
    vals = '{ox, oy, sx, sy};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t make_box(logic [2:0] kind, int cx, int cy, int ex, int ey,
                                        bit trig, int id);
    in_item_t r;
    r = '0;
    r.kind = kind;
    r.coord_x = cx;
    r.coord_y = cy;
    r.extent_x = 31'(ex);
    r.extent_y = 31'(ey);
    r.is_trigger = trig;
    r.object_id = 6'(id);
    return r;
  endfunction

  function automatic in_item_t make_tick(logic [2:0] kind, int dt);
    in_item_t r;
    r = '0;
    r.kind = kind;
    r.dt = 16'(dt);
    return r;
  endfunction

  function automatic in_item_t make_load(int px, int py, int vx, int vy, int skip);
    in_item_t r;
    r = '0;
    r.kind = KIND_LOAD;
    r.coord_x = px;
    r.coord_y = py;
    r.vel_x = vx;
    r.vel_y = vy;
    r.skip_ticks = 16'(skip);
    return r;
  endfunction

  // Whole units from -span to +span, plus a random fraction.
  function automatic int near_units(int span);
    return (int'($urandom_range(0, 2 * span)) - span) * UNIT + int'($urandom_range(0, 65535));
  endfunction

  function automatic in_item_t noise_request();
    in_item_t r;
    r = 232'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom});
    if ($urandom_range(0, 3) != 0) r.skip_ticks = 16'($urandom_range(0, 3));
    return r;
  endfunction

  // One tick with random content, sometimes preceded by a load; some box requests are random noise.
  task automatic run_tick();
    in_item_t r;
    int n;
    if ($urandom_range(0, 3) == 0)
      send_request(make_load(near_units(200), near_units(200), near_units(40),
                             near_units(40), ($urandom_range(0, 5) == 0) ? 2 : 0));
    send_request(make_tick(KIND_BEGIN, ($urandom_range(0, 30) == 0) ? 0
                                                                   : $urandom_range(1, 65535)));
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      r = make_box($urandom_range(0, 1) ? KIND_COLLIDER : KIND_BODY, near_units(220),
                   near_units(220), $urandom_range(0, 60 * UNIT), $urandom_range(0, 60 * UNIT),
                   1'($urandom_range(0, 1)), $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) r = noise_request();
      send_request(r);
    end
    send_request(make_tick(KIND_END, ($urandom_range(0, 30) == 0) ? 0
                                                                 : $urandom_range(1, 65535)));
  endtask

  initial begin
    int phase;
    int phase_goal;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset register values: a one-unit box.
    send_request(make_load(10 * UNIT, 10 * UNIT, 2 * UNIT, -3 * UNIT, 0));
    send_request(make_tick(KIND_BEGIN, 0));
    send_request(make_tick(KIND_END, 0));
    send_request(make_tick(KIND_BEGIN, 32768));
    // Floor, ceiling and both walls around the box at (10.5, 7.5).
    send_request(make_box(KIND_COLLIDER, 10 * UNIT, 8 * UNIT + 19661, 3 * UNIT, 2 * UNIT, 0, 1));
    send_request(make_box(KIND_COLLIDER, 10 * UNIT, 6 * UNIT, 3 * UNIT, 111411, 0, 2));
    send_request(make_box(KIND_COLLIDER, 11 * UNIT + 19661, 6 * UNIT, 2 * UNIT, 5 * UNIT, 0, 3));
    send_request(make_box(KIND_COLLIDER, 9 * UNIT, 6 * UNIT, 111411, 5 * UNIT, 0, 4));
    // Trigger and body membership entering then leaving.
    send_request(make_box(KIND_COLLIDER, 0, 0, 40 * UNIT, 40 * UNIT, 1, 5));
    send_request(make_box(KIND_COLLIDER, 90 * UNIT, 0, UNIT, UNIT, 1, 5));
    send_request(make_box(KIND_BODY, 0, 0, 40 * UNIT, 40 * UNIT, 0, 63));
    send_request(make_box(KIND_BODY, -90 * UNIT, 0, UNIT, UNIT, 0, 63));
    send_request(make_tick(KIND_END, 65535));
    send_request(make_tick(3'd5, 100));
    send_request(make_tick(3'd6, 100));
    send_request(make_tick(3'd7, 100));
    // Saturating motion at the top of the range, then a huge solid collider.
    send_request(make_load(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    send_request(make_tick(KIND_BEGIN, 65535));
    send_request(make_box(KIND_COLLIDER, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 0, 0));
    send_request(make_tick(KIND_END, 1));
    // Longest skip count: the tick is ignored.
    send_request(make_load(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 65535));
    send_request(make_tick(KIND_BEGIN, 65535));
    send_request(make_box(KIND_BODY, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 9));
    send_request(make_tick(KIND_END, 65535));
    send_request(make_load(0, 0, 0, 0, 0));

    // Random phases, each under its own register setting.
    phase = 0;
    while (requests_sent < ITEM_GOAL) begin
      drain_block();
      jitter_on = (phase % 3) != 1;
      case (phase)
        0: write_regs(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        1: write_regs(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
        2: write_regs(32'h0, 32'h0, 32'h7FFFFFFF, 32'h0);
        default: write_regs(near_units(10), near_units(10), $urandom_range(1, 20 * UNIT),
                            $urandom_range(1, 20 * UNIT));
      endcase
      phase_goal = requests_sent + ((phase < 3) ? 120 : 350);
      while (requests_sent < phase_goal) run_tick();
      phase++;
    end

    drain_block();
    $display("Ran %0d requests over %0d register settings plus reset values;",
             requests_sent, settings_used);
    $display("checked %0d events with jittered and steady handshakes.", events_checked);
    if (pending != 0) $display("%0d expected events never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
